[sv/segclass_pkg.sv]
`default_nettype none

package segclass_pkg;

  localparam int unsigned COORD_BITS_DEF      = 16;
  localparam int unsigned PARAM_FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    REL_COLLINEAR = 2'd0,
    REL_PARALLEL  = 2'd1,
    REL_CROSS     = 2'd2,
    REL_NO_CROSS  = 2'd3
  } rel_e;

endpackage

`default_nettype wire

[sv/segclass_cross.sv]
`default_nettype none

// Three stages: edge vectors, the six products, then the three cross products.
module segclass_cross import segclass_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned DW = COORD_BITS + 1,
  localparam int unsigned PW = 2 * COORD_BITS + 1,
  localparam int unsigned CW = 2 * COORD_BITS + 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              stall_o,
  input  wire logic signed [COORD_BITS-1:0] first_org_x_i,
  input  wire logic signed [COORD_BITS-1:0] first_org_y_i,
  input  wire logic signed [COORD_BITS-1:0] first_dest_x_i,
  input  wire logic signed [COORD_BITS-1:0] first_dest_y_i,
  input  wire logic signed [COORD_BITS-1:0] second_org_x_i,
  input  wire logic signed [COORD_BITS-1:0] second_org_y_i,
  input  wire logic signed [COORD_BITS-1:0] second_dest_x_i,
  input  wire logic signed [COORD_BITS-1:0] second_dest_y_i,
  output logic                              valid_o,
  input  wire logic                         stall_i,
  output logic signed [CW-1:0]              den_o,
  output logic signed [CW-1:0]              tnum_o,
  output logic signed [CW-1:0]              snum_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  logic signed [DW-1:0] ux_d, uy_d, vx_d, vy_d, wx_d, wy_d;
  logic signed [DW-1:0] ux_q, uy_q, vx_q, vy_q, wx_q, wy_q;

  logic signed [PW-1:0] uxvy_d, uyvx_d, wxvy_d, wyvx_d, uxwy_d, uywx_d;
  logic signed [PW-1:0] uxvy_q, uyvx_q, wxvy_q, wyvx_q, uxwy_q, uywx_q;

  logic signed [CW-1:0] den_d, tnum_d, snum_d;
  logic signed [CW-1:0] den_q, tnum_q, snum_q;

  // A stage takes a new word when it is empty or its word moves on.
  assign en3     = !v3_q || !stall_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  assign ux_d = DW'(first_dest_x_i) - DW'(first_org_x_i);
  assign uy_d = DW'(first_dest_y_i) - DW'(first_org_y_i);
  assign vx_d = DW'(second_dest_x_i) - DW'(second_org_x_i);
  assign vy_d = DW'(second_dest_y_i) - DW'(second_org_y_i);
  assign wx_d = DW'(second_org_x_i) - DW'(first_org_x_i);
  assign wy_d = DW'(second_org_y_i) - DW'(first_org_y_i);

  assign uxvy_d = PW'(ux_q) * PW'(vy_q);
  assign uyvx_d = PW'(uy_q) * PW'(vx_q);
  assign wxvy_d = PW'(wx_q) * PW'(vy_q);
  assign wyvx_d = PW'(wy_q) * PW'(vx_q);
  assign uxwy_d = PW'(ux_q) * PW'(wy_q);
  assign uywx_d = PW'(uy_q) * PW'(wx_q);

  // The parameter along the second segment uses the negated cross(u, w).
  assign den_d  = CW'(uxvy_q) - CW'(uyvx_q);
  assign tnum_d = CW'(wxvy_q) - CW'(wyvx_q);
  assign snum_d = CW'(uywx_q) - CW'(uxwy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      ux_q <= ux_d;
      uy_q <= uy_d;
      vx_q <= vx_d;
      vy_q <= vy_d;
      wx_q <= wx_d;
      wy_q <= wy_d;
    end
    if (en2 && v1_q) begin
      uxvy_q <= uxvy_d;
      uyvx_q <= uyvx_d;
      wxvy_q <= wxvy_d;
      wyvx_q <= wyvx_d;
      uxwy_q <= uxwy_d;
      uywx_q <= uywx_d;
    end
    if (en3 && v2_q) begin
      den_q  <= den_d;
      tnum_q <= tnum_d;
      snum_q <= snum_d;
    end
  end

  assign valid_o = v3_q;
  assign den_o   = den_q;
  assign tnum_o  = tnum_q;
  assign snum_o  = snum_q;

endmodule

`default_nettype wire

[sv/segclass_norm.sv]
`default_nettype none

// Two stages: make the denominator positive, then classify the pair and
// prepare the first quotient bit of both divisions.
module segclass_norm import segclass_pkg::*; #(
  parameter int unsigned COORD_BITS      = COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF,
  localparam int unsigned CW = 2 * COORD_BITS + 2,
  localparam int unsigned MW = 2 * COORD_BITS + 1,
  localparam int unsigned QW = PARAM_FRAC_BITS + 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      stall_o,
  input  wire logic signed [CW-1:0] den_i,
  input  wire logic signed [CW-1:0] tnum_i,
  input  wire logic signed [CW-1:0] snum_i,
  output logic                      valid_o,
  input  wire logic                 stall_i,
  output rel_e                      rel_o,
  output logic [MW-1:0]             den_o,
  output logic [MW-1:0]             rt_o,
  output logic [MW-1:0]             rs_o,
  output logic [QW-1:0]             qt_o,
  output logic [QW-1:0]             qs_o
);

  logic v1_q, v2_q;
  logic en1, en2;

  logic                 neg;
  logic signed [CW-1:0] dabs;
  logic                 dz_d, sz_d;
  logic                 dz_q, sz_q;
  logic [MW-1:0]        dmag_d, dmag_q;
  logic signed [CW-1:0] tn_d, sn_d, tn_q, sn_q;

  logic          t_ok, s_ok, t_full, s_full;
  rel_e          rel_d, rel_q;
  logic [MW-1:0] rt_d, rs_d, rt_q, rs_q, den2_q;
  logic [QW-1:0] qt_d, qs_d, qt_q, qs_q;

  assign en2     = !v2_q || !stall_i;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  assign neg    = den_i[CW-1];
  assign dabs   = neg ? -den_i : den_i;
  assign dmag_d = dabs[MW-1:0];
  assign tn_d   = neg ? -tnum_i : tnum_i;
  assign sn_d   = neg ? -snum_i : snum_i;
  assign dz_d   = (den_i == '0);
  assign sz_d   = (snum_i == '0);

  assign t_ok   = !tn_q[CW-1] && ($unsigned(tn_q) <= {1'b0, dmag_q});
  assign s_ok   = !sn_q[CW-1] && ($unsigned(sn_q) <= {1'b0, dmag_q});
  assign t_full = (tn_q[MW-1:0] == dmag_q);
  assign s_full = (sn_q[MW-1:0] == dmag_q);

  always_comb begin
    if (dz_q) begin
      rel_d = sz_q ? REL_COLLINEAR : REL_PARALLEL;
    end else if (t_ok && s_ok) begin
      rel_d = REL_CROSS;
    end else begin
      rel_d = REL_NO_CROSS;
    end
  end

  // A numerator equal to the denominator gives the integer bit and leaves
  // no remainder.
  assign qt_d = {{(QW-1){1'b0}}, t_full};
  assign qs_d = {{(QW-1){1'b0}}, s_full};
  assign rt_d = t_full ? '0 : tn_q[MW-1:0];
  assign rs_d = s_full ? '0 : sn_q[MW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      dz_q   <= dz_d;
      sz_q   <= sz_d;
      dmag_q <= dmag_d;
      tn_q   <= tn_d;
      sn_q   <= sn_d;
    end
    if (en2 && v1_q) begin
      rel_q  <= rel_d;
      den2_q <= dmag_q;
      rt_q   <= rt_d;
      rs_q   <= rs_d;
      qt_q   <= qt_d;
      qs_q   <= qs_d;
    end
  end

  assign valid_o = v2_q;
  assign rel_o   = rel_q;
  assign den_o   = den2_q;
  assign rt_o    = rt_q;
  assign rs_o    = rs_q;
  assign qt_o    = qt_q;
  assign qs_o    = qs_q;

endmodule

`default_nettype wire

[sv/segclass_div_step.sv]
`default_nettype none

// One restoring division step for both parameters, one register stage.
module segclass_div_step import segclass_pkg::*; #(
  parameter int unsigned MW = 2 * COORD_BITS_DEF + 1,
  parameter int unsigned QW = PARAM_FRAC_BITS_DEF + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire rel_e          rel_i,
  input  wire logic [MW-1:0] den_i,
  input  wire logic [MW-1:0] rt_i,
  input  wire logic [MW-1:0] rs_i,
  input  wire logic [QW-1:0] qt_i,
  input  wire logic [QW-1:0] qs_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output rel_e               rel_o,
  output logic [MW-1:0]      den_o,
  output logic [MW-1:0]      rt_o,
  output logic [MW-1:0]      rs_o,
  output logic [QW-1:0]      qt_o,
  output logic [QW-1:0]      qs_o
);

  logic          v_q, en;
  logic [MW:0]   rt2, rs2, rt_sub, rs_sub;
  logic          t_ge, s_ge;
  rel_e          rel_q;
  logic [MW-1:0] den_q, rt_q, rs_q;
  logic [QW-1:0] qt_q, qs_q;

  assign en      = !v_q || !stall_i;
  assign stall_o = !en;

  // The remainder stays below the denominator, so the shifted value is
  // below twice the denominator and one subtraction suffices.
  assign rt2    = {rt_i, 1'b0};
  assign rs2    = {rs_i, 1'b0};
  assign rt_sub = rt2 - {1'b0, den_i};
  assign rs_sub = rs2 - {1'b0, den_i};
  assign t_ge   = !rt_sub[MW];
  assign s_ge   = !rs_sub[MW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      rel_q <= rel_i;
      den_q <= den_i;
      rt_q  <= t_ge ? rt_sub[MW-1:0] : rt2[MW-1:0];
      rs_q  <= s_ge ? rs_sub[MW-1:0] : rs2[MW-1:0];
      qt_q  <= {qt_i[QW-2:0], t_ge};
      qs_q  <= {qs_i[QW-2:0], s_ge};
    end
  end

  assign valid_o = v_q;
  assign rel_o   = rel_q;
  assign den_o   = den_q;
  assign rt_o    = rt_q;
  assign rs_o    = rs_q;
  assign qt_o    = qt_q;
  assign qs_o    = qs_q;

endmodule

`default_nettype wire

[sv/segment_intersection_classify.sv]
`default_nettype none

// Segment pair classifier. Each accepted word carries two segments with
// signed COORD_BITS coordinates; the result word gives the relation
// (collinear, parallel, crossing, or skew without a crossing) and, for a
// crossing, the parameters along both segments with PARAM_FRAC_BITS
// fraction bits, truncated. The block takes one word per cycle unless
// in_stall_o is raised, and each result passes through the stages in turn:
// three stages form the cross products, two make the denominator positive
// and classify, and the two divisions run side by side as one quotient
// bit per pipeline stage. Every stage holds a valid bit and refills as
// soon as its word moves on, so out_stall_i only holds up new words once
// the stages between it and the input are full.
module segment_intersection_classify import segclass_pkg::*; #(
  parameter int unsigned COORD_BITS      = COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] first_org_x_i,
  input  wire logic signed [COORD_BITS-1:0] first_org_y_i,
  input  wire logic signed [COORD_BITS-1:0] first_dest_x_i,
  input  wire logic signed [COORD_BITS-1:0] first_dest_y_i,
  input  wire logic signed [COORD_BITS-1:0] second_org_x_i,
  input  wire logic signed [COORD_BITS-1:0] second_org_y_i,
  input  wire logic signed [COORD_BITS-1:0] second_dest_x_i,
  input  wire logic signed [COORD_BITS-1:0] second_dest_y_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [1:0]                        relation_o,
  output logic [PARAM_FRAC_BITS:0]          param_first_o,
  output logic [PARAM_FRAC_BITS:0]          param_second_o
);

  localparam int unsigned CW = 2 * COORD_BITS + 2;
  localparam int unsigned MW = 2 * COORD_BITS + 1;
  localparam int unsigned QW = PARAM_FRAC_BITS + 1;
  localparam int unsigned NS = PARAM_FRAC_BITS;

  logic                 x_valid, x_stall;
  logic signed [CW-1:0] x_den, x_tnum, x_snum;

  logic          d_valid [NS+1];
  logic          d_stall [NS+1];
  rel_e          d_rel   [NS+1];
  logic [MW-1:0] d_den   [NS+1];
  logic [MW-1:0] d_rt    [NS+1];
  logic [MW-1:0] d_rs    [NS+1];
  logic [QW-1:0] d_qt    [NS+1];
  logic [QW-1:0] d_qs    [NS+1];

  segclass_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_i),
    .stall_o         (in_stall_o),
    .first_org_x_i   (first_org_x_i),
    .first_org_y_i   (first_org_y_i),
    .first_dest_x_i  (first_dest_x_i),
    .first_dest_y_i  (first_dest_y_i),
    .second_org_x_i  (second_org_x_i),
    .second_org_y_i  (second_org_y_i),
    .second_dest_x_i (second_dest_x_i),
    .second_dest_y_i (second_dest_y_i),
    .valid_o         (x_valid),
    .stall_i         (x_stall),
    .den_o           (x_den),
    .tnum_o          (x_tnum),
    .snum_o          (x_snum)
  );

  segclass_norm #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (x_valid),
    .stall_o (x_stall),
    .den_i   (x_den),
    .tnum_i  (x_tnum),
    .snum_i  (x_snum),
    .valid_o (d_valid[0]),
    .stall_i (d_stall[0]),
    .rel_o   (d_rel[0]),
    .den_o   (d_den[0]),
    .rt_o    (d_rt[0]),
    .rs_o    (d_rs[0]),
    .qt_o    (d_qt[0]),
    .qs_o    (d_qs[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_div
    segclass_div_step #(
      .MW (MW),
      .QW (QW)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (d_valid[i]),
      .stall_o (d_stall[i]),
      .rel_i   (d_rel[i]),
      .den_i   (d_den[i]),
      .rt_i    (d_rt[i]),
      .rs_i    (d_rs[i]),
      .qt_i    (d_qt[i]),
      .qs_i    (d_qs[i]),
      .valid_o (d_valid[i+1]),
      .stall_i (d_stall[i+1]),
      .rel_o   (d_rel[i+1]),
      .den_o   (d_den[i+1]),
      .rt_o    (d_rt[i+1]),
      .rs_o    (d_rs[i+1]),
      .qt_o    (d_qt[i+1]),
      .qs_o    (d_qs[i+1])
    );
  end

  // The last division stage is the output register. Its remainders and
  // divisor are not needed any further.
  assign d_stall[NS] = out_stall_i;
  assign out_valid_o = d_valid[NS];
  assign relation_o  = d_rel[NS];

  // Quotients of pairs that do not cross are meaningless and read as zero.
  assign param_first_o  = (d_rel[NS] == REL_CROSS) ? d_qt[NS] : '0;
  assign param_second_o = (d_rel[NS] == REL_CROSS) ? d_qs[NS] : '0;

endmodule

`default_nettype wire

[sv/segclass_checker.sv]
`default_nettype none

module segclass_checker import segclass_pkg::*; #(
  parameter int unsigned PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [1:0]                 relation_o,
  input wire logic [PARAM_FRAC_BITS:0]   param_first_o,
  input wire logic [PARAM_FRAC_BITS:0]   param_second_o
);

  localparam logic [PARAM_FRAC_BITS:0] PARAM_ONE = (PARAM_FRAC_BITS + 1)'(1) << PARAM_FRAC_BITS;

  // Nothing leaves the block while reset is held. The check looks at the
  // following edge so that the first edge, which may still see unset
  // registers, is not judged.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result word shown during reset");

  a_zero_params: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && relation_o != REL_CROSS) |->
      (param_first_o == '0 && param_second_o == '0))
    else $error("nonzero parameter on a pair that does not cross");

  a_param_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (param_first_o <= PARAM_ONE && param_second_o <= PARAM_ONE))
    else $error("crossing parameter above one");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(relation_o) && $stable(param_first_o)
       && $stable(param_second_o)))
    else $error("stalled result word changed");

endmodule

bind segment_intersection_classify segclass_checker #(
  .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
) u_segclass_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .relation_o     (relation_o),
  .param_first_o  (param_first_o),
  .param_second_o (param_second_o)
);

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import segclass_pkg::*;

  localparam int unsigned COORD   = COORD_BITS_DEF;
  localparam int unsigned FRAC    = PARAM_FRAC_BITS_DEF;
  localparam int unsigned LATENCY = FRAC + 5;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned MAX_PRINTED = 40;

  typedef logic signed [COORD-1:0] coord_t;

  typedef struct {
    coord_t first_org_x;
    coord_t first_org_y;
    coord_t first_dest_x;
    coord_t first_dest_y;
    coord_t second_org_x;
    coord_t second_org_y;
    coord_t second_dest_x;
    coord_t second_dest_y;
  } seg_pair_t;

  typedef struct {
    rel_e          relation;
    logic [FRAC:0] param_first;
    logic [FRAC:0] param_second;
  } seg_result_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  coord_t        first_org_x_i;
  coord_t        first_org_y_i;
  coord_t        first_dest_x_i;
  coord_t        first_dest_y_i;
  coord_t        second_org_x_i;
  coord_t        second_org_y_i;
  coord_t        second_dest_x_i;
  coord_t        second_dest_y_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [1:0]    relation_o;
  logic [FRAC:0] param_first_o;
  logic [FRAC:0] param_second_o;

  seg_result_t awaited_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_off_reqs = 0;

  segment_intersection_classify i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_org_x_i  (first_org_x_i),
    .first_org_y_i  (first_org_y_i),
    .first_dest_x_i (first_dest_x_i),
    .first_dest_y_i (first_dest_y_i),
    .second_org_x_i (second_org_x_i),
    .second_org_y_i (second_org_y_i),
    .second_dest_x_i(second_dest_x_i),
    .second_dest_y_i(second_dest_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .relation_o     (relation_o),
    .param_first_o  (param_first_o),
    .param_second_o (param_second_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               awaited_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Exact relation and crossing parameters of one segment pair.
  function automatic seg_result_t classify_pair(input seg_pair_t p);
    longint ux, uy, vx, vy, wx, wy;
    longint den, t_num, s_num;
    seg_result_t r;
    ux = longint'(p.first_dest_x) - longint'(p.first_org_x);
    uy = longint'(p.first_dest_y) - longint'(p.first_org_y);
    vx = longint'(p.second_dest_x) - longint'(p.second_org_x);
    vy = longint'(p.second_dest_y) - longint'(p.second_org_y);
    wx = longint'(p.second_org_x) - longint'(p.first_org_x);
    wy = longint'(p.second_org_y) - longint'(p.first_org_y);
    den   = ux * vy - uy * vx;
    t_num = wx * vy - wy * vx;
    s_num = uy * wx - ux * wy;
    r.param_first  = '0;
    r.param_second = '0;
    if (den == 0) begin
      r.relation = (s_num == 0) ? REL_COLLINEAR : REL_PARALLEL;
    end else begin
      if (den < 0) begin
        den   = -den;
        t_num = -t_num;
        s_num = -s_num;
      end
      if (t_num >= 0 && t_num <= den && s_num >= 0 && s_num <= den) begin
        r.relation     = REL_CROSS;
        // Both numerators are below 2^34, so the shifted value cannot overflow.
        r.param_first  = (FRAC+1)'((t_num << FRAC) / den);
        r.param_second = (FRAC+1)'((s_num << FRAC) / den);
      end else begin
        r.relation = REL_NO_CROSS;
      end
    end
    return r;
  endfunction

  function automatic int rnd(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Random pair, mostly shaped so that crossings, collinear and parallel
  // lines show up often; plain full-range words cover every input bit.
  function automatic seg_pair_t make_random_pair();
    int c[8];
    int corner_vals[6];
    int kind, px, py, ux, uy, vx, vy, sx, sy;
    seg_pair_t p;
    corner_vals = '{-32768, -32767, -1, 0, 1, 32767};
    kind = rnd(0, 99);
    px = rnd(-16000, 16000);
    py = rnd(-16000, 16000);
    ux = rnd(-100, 100);
    uy = rnd(-100, 100);
    vx = rnd(-100, 100);
    vy = rnd(-100, 100);
    if (kind < 30) begin
      foreach (c[i]) c[i] = rnd(-32768, 32767);
    end else if (kind < 60) begin
      // Both segments run through a common lattice point.
      c[0] = px - rnd(0, 100) * ux;
      c[1] = py - (c[0] - px == 0 ? 0 : 0);
      sx = rnd(0, 100);
      c[0] = px - sx * ux;
      c[1] = py - sx * uy;
      sx = rnd(0, 100);
      c[2] = px + sx * ux;
      c[3] = py + sx * uy;
      sx = rnd(0, 100);
      c[4] = px - sx * vx;
      c[5] = py - sx * vy;
      sx = rnd(0, 100);
      c[6] = px + sx * vx;
      c[7] = py + sx * vy;
    end else if (kind < 80) begin
      // Four points on one line; for half of them the second is shifted.
      sx = 0;
      sy = 0;
      if (kind >= 70) begin
        sx = rnd(-1000, 1000);
        sy = rnd(-1000, 1000);
      end
      for (int i = 0; i < 4; i++) begin
        vx = rnd(-100, 100);
        c[2*i]   = px + vx * ux + ((i >= 2) ? sx : 0);
        c[2*i+1] = py + vx * uy + ((i >= 2) ? sy : 0);
      end
    end else if (kind < 90) begin
      foreach (c[i]) c[i] = rnd(-8, 8);
    end else if (kind < 95) begin
      foreach (c[i]) c[i] = rnd(-32768, 32767);
      sx = rnd(0, 2);
      if (sx != 1) begin
        c[2] = c[0];
        c[3] = c[1];
      end
      if (sx != 0) begin
        c[6] = c[4];
        c[7] = c[5];
      end
    end else begin
      foreach (c[i]) c[i] = corner_vals[rnd(0, 5)];
    end
    p.first_org_x   = coord_t'(c[0]);
    p.first_org_y   = coord_t'(c[1]);
    p.first_dest_x  = coord_t'(c[2]);
    p.first_dest_y  = coord_t'(c[3]);
    p.second_org_x  = coord_t'(c[4]);
    p.second_org_y  = coord_t'(c[5]);
    p.second_dest_x = coord_t'(c[6]);
    p.second_dest_y = coord_t'(c[7]);
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Called at a rising edge; returns at the edge where the word is taken.
  // Valid stays high so a following call keeps the sender streaming.
  task automatic send_pair(input seg_pair_t p);
    in_valid_i      <= 1'b1;
    first_org_x_i   <= p.first_org_x;
    first_org_y_i   <= p.first_org_y;
    first_dest_x_i  <= p.first_dest_x;
    first_dest_y_i  <= p.first_dest_y;
    second_org_x_i  <= p.second_org_x;
    second_org_y_i  <= p.second_org_y;
    second_dest_x_i <= p.second_dest_x;
    second_dest_y_i <= p.second_dest_y;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    awaited_results.push_back(classify_pair(p));
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    seg_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending, relation %0d",
                                  relation_o));
      end else begin
        want = awaited_results.pop_front();
        if (relation_o !== want.relation)
          report_mismatch($sformatf("relation %0d, expected %0d", relation_o,
                                    want.relation));
        if (param_first_o !== want.param_first)
          report_mismatch($sformatf("param_first %0d, expected %0d", param_first_o,
                                    want.param_first));
        if (param_second_o !== want.param_second)
          report_mismatch($sformatf("param_second %0d, expected %0d", param_second_o,
                                    want.param_second));
      end
    end
  end

  // Receiver: stall density changes every so often, with calm stretches,
  // and a long hold-off whenever the stimulus asks for one.
  initial begin : receiver
    int unsigned hold_cnt;
    int unsigned mode_cnt;
    int unsigned stall_pct;
    int unsigned seen_reqs;
    hold_cnt  = 0;
    mode_cnt  = 0;
    stall_pct = 0;
    seen_reqs = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (seen_reqs != hold_off_reqs) begin
        seen_reqs = hold_off_reqs;
        hold_cnt  = HOLD_OFF_CYCLES;
      end
      if (mode_cnt == 0) begin
        mode_cnt = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_cnt--;
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic test_directed_cases();
    send_pair('{0, 0, 10, 10, 0, 10, 10, 0});
    send_pair('{0, 0, 10, 10, 10, 0, 0, 10});
    send_pair('{-1, -1, 1, 1, 1, -1, -1, 1});
    // Touching at the ends: parameters of exactly one and exactly zero.
    send_pair('{0, 0, 4, 0, 4, 0, 4, 5});
    send_pair('{0, 0, 4, 0, 0, 0, 0, -3});
    send_pair('{0, 0, 0, 10, -5, 10, 5, 10});
    send_pair('{0, 0, 10, 0, 5, 0, 20, 0});
    send_pair('{0, 0, 10, 0, 0, 1, 10, 1});
    // Lines that meet outside one of the segments.
    send_pair('{0, 0, 1, 1, 5, 0, 6, -3});
    send_pair('{0, 0, 10, 0, 5, 1, 5, 100});
    send_pair('{0, 0, 10, 0, 11, -5, 11, 5});
    // Zero-length segments.
    send_pair('{3, 3, 3, 3, 0, 0, 5, 7});
    send_pair('{0, 0, 5, 5, 9, 1, 9, 1});
    send_pair('{2, -2, 2, -2, 2, -2, 2, -2});
    send_pair('{2, -2, 2, -2, 7, 1, 7, 1});
    // Coordinate extremes.
    send_pair('{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768});
    send_pair('{-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767});
    send_pair('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
    send_pair('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
    send_pair('{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767});
    send_pair('{-32768, 0, 32767, 0, -32767, -1, -32767, 32767});
    send_pair('{32767, -32768, -32768, 32767, 0, 0, -1, -1});
    send_pair('{-32768, 32767, 32767, 32767, 0, -32768, 0, 32767});
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      repeat ($urandom_range(1, 40)) begin
        send_pair(make_random_pair());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 8)) @(posedge clk_i);
      end
    end
  endtask

  // The receiver holds off while words keep coming, so the pipeline fills
  // and the input stalls; then the sender waits for every result.
  task automatic test_output_hold_off();
    hold_off_reqs++;
    repeat (150) send_pair(make_random_pair());
    wait_for_drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    first_org_x_i   = '0;
    first_org_y_i   = '0;
    first_dest_x_i  = '0;
    first_dest_y_i  = '0;
    second_org_x_i  = '0;
    second_org_y_i  = '0;
    second_dest_x_i = '0;
    second_dest_y_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_traffic(800);
    test_output_hold_off();
    test_random_traffic(800);
    wait_for_drain();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
sv/segclass_pkg.sv
sv/segclass_cross.sv
sv/segclass_norm.sv
sv/segclass_div_step.sv
sv/segment_intersection_classify.sv
sv/segclass_checker.sv
dv/tb_top.sv
